// ----- hw/rtl/cfrt_pkg.sv -----
package cfrt_pkg;

    // Field count saturates at the smaller of MAX_FIELDS and the 10-bit range.
    localparam int MAX_FIELDS  = 1023;
    localparam int CNT_W       = 10;
    localparam int CNT_MAX     = (1 << CNT_W) - 1;
    localparam int COUNT_LIMIT = (MAX_FIELDS < CNT_MAX) ? MAX_FIELDS : CNT_MAX;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_QUOTE = 8'd34;

    // Register map, word index taken from paddr[3:2]
    localparam int          ADDR_W      = 4;
    localparam logic [1:0]  REG_SEP     = 2'd0;
    localparam logic [1:0]  REG_CHECK   = 2'd1;
    localparam logic [1:0]  REG_EXPECT  = 2'd2;
    localparam logic [7:0]  SEP_RESET   = 8'd44;

    typedef enum logic [2:0] {
        M_ROW     = 3'd0,
        M_FSTART  = 3'd1,
        M_UNQ     = 3'd2,
        M_QUOTED  = 3'd3,
        M_QSEEN   = 3'd4,
        M_AFTERCR = 3'd5,
        M_DRAIN   = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_FEND = 2'd1,
        KIND_REND = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_EMBEDDED = 3'd1,
        ERR_AFTER_Q  = 3'd2,
        ERR_EOF_Q    = 3'd3,
        ERR_COUNT    = 3'd4
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_beat_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data;
        logic [CNT_W-1:0] field_count;
        err_t             error_code;
        logic             last;
    } out_beat_t;

    typedef struct packed {
        logic [7:0]       separator_char;
        logic             check_count;
        logic [CNT_W-1:0] expected_fields;
    } cfg_t;

    // What the parser hands to the result queue for one accepted item
    typedef struct packed {
        logic [1:0] n;
        out_beat_t  r0;
        out_beat_t  r1;
    } step_t;

endpackage

// ----- hw/rtl/csv_field_row_tokenizer_top.sv -----
// Channel   Handshake          Payload                           Beats per item
// in        in_valid/in_ready  in_item  (data_byte, end_of_input) 1
// out       out_valid/out_ready out_item (kind, data, field_count,
//                                         error_code, last)        0 to 2
// apb       psel/penable/pready paddr, pwdata, prdata             -
//
// One item is parsed in the cycle it is accepted; its results land in a
// four-entry result queue the next edge, so an item can enter every cycle
// while the queue has room. The queue drains one beat per cycle while
// out_ready is high, so items giving two results (field end plus row end)
// take two beats; one item per cycle holds while each gives at most one.
// in_ready holds low while the queue lacks room for two beats; it never
// depends on out_ready in the same cycle. Reset clears the parser state,
// the queue pointers and the registers to their defaults.
module csv_field_row_tokenizer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cfrt_pkg::in_beat_t            in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cfrt_pkg::out_beat_t           out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cfrt_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import cfrt_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    step_t      step;
    logic       take;
    logic       wr_en;
    logic [1:0] reg_idx;

    // Register file: writes land on the access beat, no wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        case (reg_idx)
            REG_SEP:    prdata = {24'd0, cfg_reg.separator_char};
            REG_CHECK:  prdata = {31'd0, cfg_reg.check_count};
            REG_EXPECT: prdata = {{(32-CNT_W){1'b0}}, cfg_reg.expected_fields};
            default:    prdata = '0;
        endcase
        if (wr_en) begin
            case (reg_idx)
                REG_SEP:    cfg_next.separator_char  = pwdata[7:0];
                REG_CHECK:  cfg_next.check_count     = pwdata[0];
                REG_EXPECT: cfg_next.expected_fields = pwdata[CNT_W-1:0];
                default:    ; // drop writes outside the map
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.separator_char  <= SEP_RESET;
            cfg_reg.check_count     <= 1'b0;
            cfg_reg.expected_fields <= '0;
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

    // Advance the parser only on an accepted input beat.
    assign take = in_valid && in_ready;

    cfrt_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .beat  (in_item),
        .cfg   (cfg_reg),
        .step  (step)
    );

    // Hold results until the consumer takes them.
    cfrt_out_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (take),
        .step  (step),
        .room  (in_ready),
        .valid (out_valid),
        .ready (out_ready),
        .head  (out_item)
    );

endmodule

// ----- hw/rtl/cfrt_parser.sv -----
module cfrt_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  cfrt_pkg::in_beat_t beat,
    input  cfrt_pkg::cfg_t    cfg,
    output cfrt_pkg::step_t   step
);
    import cfrt_pkg::*;

    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [7:0]       b;
    logic             line_end, is_ws, is_sep, is_quote;
    logic             row_path, field_path;
    logic [CNT_W-1:0] cnt_inc;
    out_beat_t        fend, rend_cur, rend_inc;

    function automatic out_beat_t row_close(input logic [CNT_W-1:0] c, input cfg_t cf);
        out_beat_t r;
        r = '0;
        r.field_count = c;
        if (cf.check_count && (c != cf.expected_fields)) begin
            r.kind       = KIND_ERR;
            r.error_code = ERR_COUNT;
        end
        else begin
            r.kind = KIND_REND;
        end
        return r;
    endfunction

    function automatic out_beat_t data_beat(input logic [7:0] d);
        out_beat_t r;
        r = '0;
        r.kind = KIND_DATA;
        r.data = d;
        return r;
    endfunction

    function automatic out_beat_t err_beat(input err_t e);
        out_beat_t r;
        r = '0;
        r.kind       = KIND_ERR;
        r.error_code = e;
        return r;
    endfunction

    always_comb
    begin
        b        = beat.data_byte;
        line_end = (b == CH_LF) || (b == CH_CR);
        is_ws    = (b == CH_SP) || (b == CH_TAB);
        is_sep   = (b == cfg.separator_char);
        is_quote = (b == CH_QUOTE);
        cnt_inc  = (cnt_reg < CNT_W'(COUNT_LIMIT)) ? cnt_reg + CNT_W'(1) : cnt_reg;
        fend      = '0;
        fend.kind = KIND_FEND;
        rend_cur  = row_close(cnt_reg, cfg);
        rend_inc  = row_close(cnt_inc, cfg);

        step       = '0;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        row_path   = 1'b0;
        field_path = 1'b0;

        if (beat.end_of_input) begin
            case (mode_reg)
                M_FSTART, M_UNQ, M_QSEEN:
                begin
                    step.n  = 2'd2;
                    step.r0 = fend;
                    step.r1 = rend_inc;
                end
                M_QUOTED:
                begin
                    step.n  = 2'd1;
                    step.r0 = err_beat(ERR_EOF_Q);
                end
                default: ;
            endcase
            mode_next = M_ROW;
            cnt_next  = '0;
        end
        else begin
            case (mode_reg)
                M_AFTERCR:
                begin
                    if (b == CH_LF)
                        mode_next = M_ROW;
                    else
                        row_path = 1'b1;
                end
                M_ROW:    row_path = 1'b1;
                M_FSTART: field_path = 1'b1;
                M_UNQ:
                begin
                    if (is_quote) begin
                        step.n    = 2'd1;
                        step.r0   = err_beat(ERR_EMBEDDED);
                        cnt_next  = '0;
                        mode_next = M_DRAIN;
                    end
                    else if (is_sep) begin
                        step.n    = 2'd1;
                        step.r0   = fend;
                        cnt_next  = cnt_inc;
                        mode_next = M_FSTART;
                    end
                    else if (line_end) begin
                        step.n    = 2'd2;
                        step.r0   = fend;
                        step.r1   = rend_inc;
                        cnt_next  = '0;
                        mode_next = (rend_inc.kind == KIND_ERR) ? M_DRAIN :
                                    (b == CH_CR) ? M_AFTERCR : M_ROW;
                    end
                    else begin
                        step.n  = 2'd1;
                        step.r0 = data_beat(b);
                    end
                end
                M_QUOTED:
                begin
                    if (is_quote) begin
                        mode_next = M_QSEEN;
                    end
                    else begin
                        step.n  = 2'd1;
                        step.r0 = data_beat(b);
                    end
                end
                M_QSEEN:
                begin
                    if (is_quote) begin
                        step.n    = 2'd1;
                        step.r0   = data_beat(CH_QUOTE);
                        mode_next = M_QUOTED;
                    end
                    else if (is_sep) begin
                        step.n    = 2'd1;
                        step.r0   = fend;
                        cnt_next  = cnt_inc;
                        mode_next = M_FSTART;
                    end
                    else if (line_end) begin
                        step.n    = 2'd2;
                        step.r0   = fend;
                        step.r1   = rend_inc;
                        cnt_next  = '0;
                        mode_next = (rend_inc.kind == KIND_ERR) ? M_DRAIN :
                                    (b == CH_CR) ? M_AFTERCR : M_ROW;
                    end
                    else begin
                        step.n    = 2'd1;
                        step.r0   = err_beat(ERR_AFTER_Q);
                        cnt_next  = '0;
                        mode_next = M_DRAIN;
                    end
                end
                M_DRAIN: ;
                default:  row_path = 1'b1;
            endcase

            if (row_path) begin
                mode_next = M_ROW;
                if (is_ws) begin
                    // skip leading blanks
                end
                else if (line_end) begin
                    step.n    = 2'd1;
                    step.r0   = rend_cur;
                    cnt_next  = '0;
                    mode_next = (rend_cur.kind == KIND_ERR) ? M_DRAIN :
                                (b == CH_CR) ? M_AFTERCR : M_ROW;
                end
                else begin
                    field_path = 1'b1;
                end
            end

            if (field_path) begin
                if (is_quote) begin
                    mode_next = M_QUOTED;
                end
                else if (is_sep) begin
                    step.n    = 2'd1;
                    step.r0   = fend;
                    cnt_next  = cnt_inc;
                    mode_next = M_FSTART;
                end
                else if (line_end) begin
                    step.n    = 2'd2;
                    step.r0   = fend;
                    step.r1   = rend_inc;
                    cnt_next  = '0;
                    mode_next = (rend_inc.kind == KIND_ERR) ? M_DRAIN :
                                (b == CH_CR) ? M_AFTERCR : M_ROW;
                end
                else begin
                    step.n    = 2'd1;
                    step.r0   = data_beat(b);
                    mode_next = M_UNQ;
                end
            end
        end

        // mark the final result of this item
        step.r0.last = (step.n == 2'd1);
        step.r1.last = (step.n == 2'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_ROW;
            cnt_reg  <= '0;
        end
        else if (take) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/cfrt_out_queue.sv -----
module cfrt_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cfrt_pkg::step_t    step,
    output logic               room,
    output logic               valid,
    input  logic               ready,
    output cfrt_pkg::out_beat_t head
);
    import cfrt_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    out_beat_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next, rd_reg, rd_next, wr_plus1;
    logic [PTR_W:0]     cnt_reg, cnt_next;
    logic [1:0]         n_push;
    logic               pop;

    assign room     = (cnt_reg <= (PTR_W+1)'(DEPTH - 2));
    assign valid    = (cnt_reg != '0);
    assign head     = mem_reg[rd_reg];
    assign pop      = valid && ready;
    assign n_push   = push ? step.n : 2'd0;
    assign wr_plus1 = wr_reg + PTR_W'(1);

    always_comb
    begin
        wr_next  = wr_reg + PTR_W'(n_push);
        rd_next  = rd_reg + PTR_W'(pop);
        cnt_next = cnt_reg + (PTR_W+1)'(n_push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem_reg[wr_reg] <= step.r0;
        if (n_push == 2'd2)
            mem_reg[wr_plus1] <= step.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- sim/csv_field_row_tokenizer_checker.sv -----
`timescale 1ns / 100ps

module csv_field_row_tokenizer_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  cfrt_pkg::in_beat_t          in_item,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  cfrt_pkg::out_beat_t         out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [cfrt_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output int                          mismatches,
    output int                          tokens_due
);
    import cfrt_pkg::*;

    // Shadow of the parser state and registers
    mode_t            parse_mode;
    logic [CNT_W-1:0] row_fields;
    logic [7:0]       sep_char;
    logic             count_check;
    logic [CNT_W-1:0] want_fields;

    out_beat_t        expected_tokens[$];
    out_beat_t        step_tokens[$];
    int               miss;

    function automatic void add_token(kind_t k, logic [7:0] d, logic [CNT_W-1:0] c, err_t e);
        out_beat_t t;
        t.kind        = k;
        t.data        = d;
        t.field_count = c;
        t.error_code  = e;
        t.last        = 1'b0;
        step_tokens   = {step_tokens, t};
    endfunction

    function automatic bit is_eol(logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic void close_field();
        if (row_fields < COUNT_LIMIT)
            row_fields++;
        add_token(KIND_FEND, 8'd0, '0, ERR_NONE);
    endfunction

    // Return 1 when the row closes on a count error
    function automatic bit close_row();
        logic [CNT_W-1:0] cnt;
        cnt = row_fields;
        row_fields = '0;
        if (count_check && cnt != want_fields)
        begin
            add_token(KIND_ERR, 8'd0, cnt, ERR_COUNT);
            return 1'b1;
        end
        add_token(KIND_REND, 8'd0, cnt, ERR_NONE);
        return 1'b0;
    endfunction

    function automatic void raise_error(err_t code);
        add_token(KIND_ERR, 8'd0, '0, code);
        row_fields = '0;
        parse_mode = M_DRAIN;
    endfunction

    function automatic void end_line(logic [7:0] c);
        close_field();
        if (close_row())
            parse_mode = M_DRAIN;
        else
            parse_mode = (c == CH_CR) ? M_AFTERCR : M_ROW;
    endfunction

    task automatic tokenize_beat(in_beat_t beat);
        logic [7:0] c;
        mode_t      m;
        bit         busy;
        out_beat_t  t;
        c = beat.data_byte;
        m = parse_mode;
        step_tokens.delete();
        if (m > M_DRAIN)
            m = M_ROW;
        if (beat.end_of_input)
        begin
            if (m == M_FSTART || m == M_UNQ || m == M_QSEEN)
            begin
                close_field();
                void'(close_row());
            end
            else if (m == M_QUOTED)
            begin
                add_token(KIND_ERR, 8'd0, '0, ERR_EOF_Q);
            end
            parse_mode = M_ROW;
            row_fields = '0;
        end
        else
        begin
            parse_mode = m;
            busy = 1'b1;
            // absorb the LF of a CRLF pair
            if (m == M_AFTERCR)
            begin
                m = M_ROW;
                parse_mode = M_ROW;
                if (c == CH_LF)
                    busy = 1'b0;
            end
            if (busy && m == M_ROW)
            begin
                if (c == CH_SP || c == CH_TAB)
                begin
                    busy = 1'b0;
                end
                else if (is_eol(c))
                begin
                    if (close_row())
                        parse_mode = M_DRAIN;
                    else
                        parse_mode = (c == CH_CR) ? M_AFTERCR : M_ROW;
                    busy = 1'b0;
                end
                else
                begin
                    m = M_FSTART;
                end
            end
            if (busy)
            begin
                case (m)
                    M_FSTART:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            parse_mode = M_QUOTED;
                        end
                        else if (c == sep_char)
                        begin
                            close_field();
                            parse_mode = M_FSTART;
                        end
                        else if (is_eol(c))
                        begin
                            end_line(c);
                        end
                        else
                        begin
                            add_token(KIND_DATA, c, '0, ERR_NONE);
                            parse_mode = M_UNQ;
                        end
                    end
                    M_UNQ:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            raise_error(ERR_EMBEDDED);
                        end
                        else if (c == sep_char)
                        begin
                            close_field();
                            parse_mode = M_FSTART;
                        end
                        else if (is_eol(c))
                        begin
                            end_line(c);
                        end
                        else
                        begin
                            add_token(KIND_DATA, c, '0, ERR_NONE);
                        end
                    end
                    M_QUOTED:
                    begin
                        if (c == CH_QUOTE)
                            parse_mode = M_QSEEN;
                        else
                            add_token(KIND_DATA, c, '0, ERR_NONE);
                    end
                    M_QSEEN:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            add_token(KIND_DATA, CH_QUOTE, '0, ERR_NONE);
                            parse_mode = M_QUOTED;
                        end
                        else if (c == sep_char)
                        begin
                            close_field();
                            parse_mode = M_FSTART;
                        end
                        else if (is_eol(c))
                        begin
                            end_line(c);
                        end
                        else
                        begin
                            raise_error(ERR_AFTER_Q);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        // mark the final beat of this item
        foreach (step_tokens[i])
        begin
            t = step_tokens[i];
            if (i == step_tokens.size() - 1)
                t.last = 1'b1;
            expected_tokens = {expected_tokens, t};
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            miss++;
        end
    endtask

    task automatic check_token(out_beat_t got);
        out_beat_t want;
        if (expected_tokens.size() == 0)
        begin
            $display("%0t: unexpected beat: expected none, got kind %0h data %0h",
                     $time, got.kind, got.data);
            miss++;
        end
        else
        begin
            want = expected_tokens.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("data", want.data, got.data);
            check_field("field_count", want.field_count, got.field_count);
            check_field("error_code", want.error_code, got.error_code);
            check_field("last", want.last, got.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_mode  = M_ROW;
            row_fields  = '0;
            sep_char    = SEP_RESET;
            count_check = 1'b0;
            want_fields = '0;
            miss        = 0;
            expected_tokens.delete();
            mismatches <= 0;
            tokens_due <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_SEP:    sep_char    = pwdata[7:0];
                    REG_CHECK:  count_check = pwdata[0];
                    REG_EXPECT: want_fields = pwdata[CNT_W-1:0];
                    default:    ;
                endcase
            end
            if (out_valid && out_ready)
                check_token(out_item);
            if (in_valid && in_ready)
                tokenize_beat(in_item);
            mismatches <= miss;
            tokens_due <= expected_tokens.size();
        end
    end

endmodule

// ----- sim/tb_csv_field_row_tokenizer_top.sv -----
`timescale 1ns / 100ps

module tb_csv_field_row_tokenizer_top;

    import cfrt_pkg::*;

    // Long enough for a receiver hold of this many cycles to back up the input
    localparam int HOLD_CYCLES = 80;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    in_beat_t            in_item;
    logic                out_valid;
    logic                out_ready;
    out_beat_t           out_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int                  mismatches;
    int                  tokens_due;

    // Stimulus-side view of the registers, used to shape well-formed rows
    logic [7:0]          sep_now;
    logic                check_now;
    logic [CNT_W-1:0]    want_now;

    int                  beats_sent;
    int                  in_idle_pct;
    int                  out_idle_pct;
    logic                hold_toggle;

    csv_field_row_tokenizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    csv_field_row_tokenizer_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .tokens_due (tokens_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case a handshake hangs
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random back-pressure, plus a long hold whenever the
    // stimulus flips hold_toggle. Count the hold here, not in the sender.
    initial
    begin
        bit seen;
        seen = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_toggle != seen)
            begin
                seen = hold_toggle;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // Offer one beat and hold it until accepted. Idle first at random so
    // gaps land on every parser state.
    task automatic send_beat(logic [7:0] value, bit eof);
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= {value, eof};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_eof();
        send_beat(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    // Content byte; unquoted fields avoid the bytes that would end them
    function automatic logic [7:0] pick_content(bit quoted);
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if (!quoted && (c == CH_QUOTE || c == sep_now || c == CH_CR || c == CH_LF))
            c = 8'(8'h61 + $urandom_range(25));
        return c;
    endfunction

    // One row of nfields fields; noisy rows get stray bytes of any value
    task automatic send_row(int nfields, bit noisy);
        bit         quoted;
        int         len;
        logic [7:0] c;
        if ($urandom_range(9) == 0)
            send_beat($urandom_range(1) ? CH_SP : CH_TAB, 1'b0);
        for (int k = 0; k < nfields; k++)
        begin
            if (k > 0)
                send_beat(sep_now, 1'b0);
            quoted = 1'($urandom_range(1));
            len = $urandom_range(4);
            if (quoted)
                send_beat(CH_QUOTE, 1'b0);
            for (int j = 0; j < len; j++)
            begin
                c = pick_content(quoted);
                send_beat(c, 1'b0);
                // double a quote inside a quoted field
                if (quoted && c == CH_QUOTE)
                    send_beat(CH_QUOTE, 1'b0);
                if (noisy && $urandom_range(7) == 0)
                    send_beat(8'($urandom_range(255)), 1'b0);
            end
            if (quoted)
                send_beat(CH_QUOTE, 1'b0);
        end
        case ($urandom_range(2))
            0: send_beat(CH_LF, 1'b0);
            1: send_beat(CH_CR, 1'b0);
            default:
            begin
                send_beat(CH_CR, 1'b0);
                send_beat(CH_LF, 1'b0);
            end
        endcase
    endtask

    // Cut a field short with end of input: inside quotes, after the
    // closing quote, or in an unquoted field
    task automatic send_partial();
        bit quoted;
        int len;
        quoted = 1'($urandom_range(1));
        len = $urandom_range(1, 3);
        if (quoted)
            send_beat(CH_QUOTE, 1'b0);
        for (int j = 0; j < len; j++)
            send_beat(pick_content(1'b0), 1'b0);
        if (quoted && $urandom_range(1))
            send_beat(CH_QUOTE, 1'b0);
        send_eof();
    endtask

    // Mostly well-formed rows; close broken ones with end of input so the
    // drain state does not swallow the rest of the phase
    task automatic random_rows(int beats, bit eof_each_row);
        int stop;
        int pick;
        int n;
        stop = beats_sent + beats;
        while (beats_sent < stop)
        begin
            pick = $urandom_range(99);
            n = (check_now && pick < 70) ? int'(want_now) : $urandom_range(5);
            if (pick < 80)
            begin
                send_row(n, 1'b0);
                if (eof_each_row || (check_now && n != want_now))
                    send_eof();
            end
            else if (pick < 90)
            begin
                send_row(n, 1'b1);
                send_eof();
            end
            else if (pick < 95)
            begin
                send_partial();
            end
            else
            begin
                send_eof();
            end
        end
    endtask

    // Drop valid, wait for every expected beat, then let the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tokens_due != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    // Setup phase, access phase, then idle before the next write
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic [7:0] sep, logic chk, logic [CNT_W-1:0] want);
        drain_results();
        write_reg(REG_SEP, 32'(sep));
        write_reg(REG_CHECK, 32'(chk));
        write_reg(REG_EXPECT, 32'(want));
        sep_now   = sep;
        check_now = chk;
        want_now  = want;
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        out_ready    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        hold_toggle  = 1'b0;
        beats_sent   = 0;
        in_idle_pct  = 29;
        out_idle_pct = 29;
        sep_now      = SEP_RESET;
        check_now    = 1'b0;
        want_now     = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass on reset registers.
        // Unquoted field, quoted field with a doubled quote, LF.
        send_text("a,\"x\"\"y\"\n");
        // Leading space and tab skipped; CRLF ends the row once.
        send_text(" \tb");
        send_beat(CH_CR, 1'b0);
        send_beat(CH_LF, 1'b0);
        // Empty lines by LF and by CR, then a byte right after CR.
        send_beat(CH_LF, 1'b0);
        send_beat(CH_CR, 1'b0);
        send_beat(8'hFF, 1'b0);
        // End of input after a separator gives an empty last field.
        send_beat(8'h2C, 1'b0);
        send_beat(8'h00, 1'b1);
        // End of input at row start gives nothing.
        send_beat(8'hFF, 1'b1);
        // Quote inside an unquoted field, then a drained byte.
        send_text("a\"b");
        send_eof();
        // Stray byte after a closing quote.
        send_text("\"q\"z");
        send_eof();
        // End of input inside quotes.
        send_text("\"z");
        send_eof();
        random_rows(130, 1'b0);

        // Count checking on, with one good and one short row.
        configure(8'h3B, 1'b1, 10'd3);
        send_text("a;b;c\n");
        send_text("a;b\nc");
        send_eof();
        random_rows(150, 1'b0);

        // Zero separator; run a stretch with no idling on either side,
        // then hold the receiver off while the sender keeps offering beats.
        configure(8'h00, 1'b0, 10'd0);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        random_rows(60, 1'b0);
        hold_toggle <= ~hold_toggle;
        random_rows(70, 1'b0);
        in_idle_pct  = 29;
        out_idle_pct = 29;

        // All-ones separator; only empty rows satisfy a zero count.
        configure(8'hFF, 1'b1, 10'd0);
        random_rows(60, 1'b0);

        // Separator equal to the quote: the quote test wins at field start.
        configure(CH_QUOTE, 1'b0, 10'd0);
        random_rows(80, 1'b1);

        // Separator equal to LF: line end wins at row start only.
        configure(CH_LF, 1'b0, 10'd0);
        random_rows(60, 1'b1);

        // Largest expected count: every row closes on a count error.
        configure(8'h2C, 1'b1, 10'd1023);
        send_text("x,y\n");
        send_eof();

        configure(8'h2C, 1'b1, 10'd1);
        random_rows(180, 1'b0);

        drain_results();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- csv_field_row_tokenizer_top.f -----
hw/rtl/cfrt_pkg.sv
hw/rtl/cfrt_parser.sv
hw/rtl/cfrt_out_queue.sv
hw/rtl/csv_field_row_tokenizer_top.sv
sim/csv_field_row_tokenizer_checker.sv
sim/tb_csv_field_row_tokenizer_top.sv
